// ===== design/tcw_pkg.sv =====
// Package for the text console writer: geometry, widths, codes and shared structs.
// No dependencies; tcw_ram, tcw_seq and the core refer to it by scoped names.
package tcw_pkg;

  // Screen geometry
  localparam int ROWS  = 25;
  localparam int COLS  = 80;
  localparam int CELLS = ROWS * COLS;

  // Internal widths
  localparam int AW = $clog2(CELLS);     // cell address
  localparam int RW = $clog2(ROWS);      // cursor row
  localparam int CW = $clog2(COLS + 1);  // cursor column, COLS = wrap pending

  // Opcodes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Character codes with a control meaning
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] ATTR_RESET = 8'd112;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } cmd_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
  } result_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    logic [15:0]   data;
  } ram_wr_t;

endpackage

// ===== design/tcw_req_if.sv =====
// Request channel interface of the text console writer.
// Depends on nothing; payload widths follow the request fields.
interface tcw_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  char_code;
  logic [10:0] cell_index;

  modport source (output valid, output opcode, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input opcode, input char_code, input cell_index,
                  output ready);
endinterface

// ===== design/tcw_rsp_if.sv =====
// Result channel interface of the text console writer.
// Depends on nothing; payload widths follow the result fields.
interface tcw_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_col;

  modport source (output valid, output read_data, output cursor_row, output cursor_col,
                  input ready);
  modport sink   (input valid, input read_data, input cursor_row, input cursor_col,
                  output ready);
endinterface

// ===== design/tcw_ram.sv =====
// Screen cell memory: one write port, one read port, registered read data.
// Depends on tcw_pkg for depth and address width.
module tcw_ram (
  input  logic                   clk,
  input  tcw_pkg::ram_wr_t       wr,
  input  logic [tcw_pkg::AW-1:0] raddr,
  output logic [15:0]            rdata
);

  logic [15:0] mem [tcw_pkg::CELLS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/tcw_seq.sv =====
// Sequencer of the text console writer: cursor, command decode and the shared
// cell address counter that drives clears and scroll copies.
// Depends on tcw_pkg; drives the ports of tcw_ram.
module tcw_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [7:0]             attr,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  tcw_pkg::cmd_t          cmd,
  output logic                   res_valid,
  input  logic                   res_ready,
  output tcw_pkg::result_t       res,
  output tcw_pkg::ram_wr_t       ram_wr,
  output logic [tcw_pkg::AW-1:0] ram_raddr,
  input  logic [15:0]            ram_rdata
);

  localparam int AW = tcw_pkg::AW;
  localparam int RW = tcw_pkg::RW;
  localparam int CW = tcw_pkg::CW;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_RDATA   = 3'd2;
  localparam logic [2:0] ST_SCRL_RD = 3'd3;
  localparam logic [2:0] ST_SCROLL  = 3'd4;
  localparam logic [2:0] ST_TAB     = 3'd5;
  localparam logic [2:0] ST_WRITE   = 3'd6;
  localparam logic [2:0] ST_DONE    = 3'd7;

  // what follows a scroll
  localparam logic [1:0] PEND_DONE  = 2'd0;
  localparam logic [1:0] PEND_TAB   = 2'd1;
  localparam logic [1:0] PEND_WRITE = 2'd2;

  localparam logic [AW-1:0] LAST_CELL = AW'(tcw_pkg::CELLS - 1);
  localparam logic [AW-1:0] COPY_END  = AW'(tcw_pkg::CELLS - tcw_pkg::COLS);
  localparam logic [AW-1:0] READ_END  = AW'(tcw_pkg::CELLS - tcw_pkg::COLS - 1);
  localparam logic [AW-1:0] ROW_STEP  = AW'(tcw_pkg::COLS);
  localparam logic [RW-1:0] LAST_ROW  = RW'(tcw_pkg::ROWS - 1);
  localparam logic [CW-1:0] COL_END   = CW'(tcw_pkg::COLS);
  localparam logic [CW-1:0] COL_LAST  = CW'(tcw_pkg::COLS - 1);

  logic [2:0]    state;
  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [AW-1:0] ptr;
  logic [7:0]    wch;
  logic          inc;
  logic [1:0]    pend;
  logic          init_pass;
  logic          rd_ok;
  logic [15:0]   res_data;

  logic          accept;
  logic          idx_ok;
  logic          wrap;
  logic          bottom;
  logic [AW-1:0] cur_addr;
  logic [CW-1:0] col_inc;
  logic [15:0]   blank;

  assign accept   = cmd_valid && cmd_ready;
  assign idx_ok   = 32'(cmd.cell_index) < tcw_pkg::CELLS;
  assign wrap     = col >= COL_END;
  assign bottom   = row == LAST_ROW;
  assign cur_addr = AW'(AW'(row) * ROW_STEP) + AW'(col);
  assign col_inc  = CW'(col + 1'b1);
  assign blank    = {attr, tcw_pkg::CH_SPACE};

  assign cmd_ready = state == ST_IDLE;
  assign res_valid = state == ST_DONE;
  assign res.read_data  = res_data;
  assign res.cursor_row = 5'(row);
  assign res.cursor_col = 7'(col);

  // memory port control
  always_comb begin
    ram_wr.we   = 1'b0;
    ram_wr.addr = ptr;
    ram_wr.data = blank;
    ram_raddr   = '0;
    unique case (state)
      ST_CLEAR: begin
        ram_wr.we   = 1'b1;
        ram_wr.data = {init_pass ? tcw_pkg::ATTR_RESET : attr, tcw_pkg::CH_SPACE};
      end
      ST_IDLE: begin
        if (idx_ok) begin
          ram_raddr = AW'(cmd.cell_index);
        end
      end
      ST_SCRL_RD: begin
        ram_raddr = ROW_STEP;
      end
      ST_SCROLL: begin
        ram_wr.we   = 1'b1;
        ram_wr.data = (ptr < COPY_END) ? ram_rdata : blank;
        // one cell ahead of the write side; past the copy region nothing is read
        if (ptr < READ_END) begin
          ram_raddr = AW'(ptr + ROW_STEP + 1'b1);
        end
      end
      ST_TAB: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = cur_addr;
      end
      ST_WRITE: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = cur_addr;
        ram_wr.data = {attr, wch};
      end
      ST_RDATA, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      init_pass <= 1'b1;
      row       <= '0;
      col       <= '0;
      ptr       <= '0;
      pend      <= PEND_DONE;
      inc       <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (ptr == LAST_CELL) begin
            ptr       <= '0;
            init_pass <= 1'b0;
            state     <= init_pass ? ST_IDLE : ST_DONE;
          end else begin
            ptr <= AW'(ptr + 1'b1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            res_data <= '0;
            rd_ok    <= idx_ok;
            unique case (cmd.opcode)
              tcw_pkg::OP_PUT: begin
                case (cmd.char_code)
                  tcw_pkg::CH_NUL: state <= ST_DONE;
                  tcw_pkg::CH_CR: begin
                    col   <= '0;
                    state <= ST_DONE;
                  end
                  tcw_pkg::CH_LF: begin
                    if (!bottom) begin
                      row   <= RW'(row + 1'b1);
                      col   <= '0;
                      state <= ST_DONE;
                    end else begin
                      pend  <= PEND_DONE;
                      state <= ST_SCRL_RD;
                    end
                  end
                  tcw_pkg::CH_TAB: begin
                    if (!wrap) begin
                      state <= ST_TAB;
                    end else if (!bottom) begin
                      row   <= RW'(row + 1'b1);
                      col   <= '0;
                      state <= ST_TAB;
                    end else begin
                      pend  <= PEND_TAB;
                      state <= ST_SCRL_RD;
                    end
                  end
                  tcw_pkg::CH_BS: begin
                    wch <= tcw_pkg::CH_SPACE;
                    inc <= 1'b0;
                    if (col != '0) begin
                      col   <= CW'(col - 1'b1);
                      state <= ST_WRITE;
                    end else if (row != '0) begin
                      row   <= RW'(row - 1'b1);
                      col   <= COL_LAST;
                      state <= ST_WRITE;
                    end else begin
                      state <= ST_DONE;
                    end
                  end
                  default: begin
                    wch <= cmd.char_code;
                    inc <= 1'b1;
                    if (!wrap) begin
                      state <= ST_WRITE;
                    end else if (!bottom) begin
                      row   <= RW'(row + 1'b1);
                      col   <= '0;
                      state <= ST_WRITE;
                    end else begin
                      pend  <= PEND_WRITE;
                      state <= ST_SCRL_RD;
                    end
                  end
                endcase
              end
              tcw_pkg::OP_READ: state <= ST_RDATA;
              tcw_pkg::OP_CLEAR: begin
                row   <= '0;
                col   <= '0;
                ptr   <= '0;
                state <= ST_CLEAR;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_RDATA: begin
          res_data <= rd_ok ? ram_rdata : '0;
          state    <= ST_DONE;
        end
        ST_SCRL_RD: begin
          ptr   <= '0;
          state <= ST_SCROLL;
        end
        ST_SCROLL: begin
          if (ptr == LAST_CELL) begin
            ptr <= '0;
            col <= '0;
            unique case (pend)
              PEND_TAB:   state <= ST_TAB;
              PEND_WRITE: state <= ST_WRITE;
              default:    state <= ST_DONE;
            endcase
          end else begin
            ptr <= AW'(ptr + 1'b1);
          end
        end
        ST_TAB: begin
          col <= col_inc;
          if (col_inc[1:0] == 2'b00 || col_inc == COL_END) begin
            state <= ST_DONE;
          end
        end
        ST_WRITE: begin
          if (inc) begin
            col <= col_inc;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/text_console_writer_core.sv =====
// Top level of the text console writer: channels, attribute register, result register.
// Depends on tcw_pkg, tcw_req_if, tcw_rsp_if, tcw_ram and tcw_seq.
//
//   channel | dir | handshake        | payload
//   --------+-----+------------------+------------------------------------------
//   req     | in  | valid / ready    | opcode, char_code, cell_index
//   rsp     | out | valid / ready    | read_data, cursor_row, cursor_col
//   cfg     | in  | cfg_we (no wait) | cfg_wdata = text_attribute
//
// Sequencing: one transaction at a time through the sequencer. A tab writes one
// cell per cycle. A newline on the bottom row scrolls: one cell moved per cycle
// through the RAM port; a put or tab that wraps there adds its cell writes.
// A clear sweeps every cell.
// Reset: synchronous. After reset the sweep blanks all CELLS cells with the reset
// attribute before req.ready rises; cfg writes are taken meanwhile.
// Stalls: the result register frees the sequencer, so a new request is taken
// while a result waits on rsp.ready; a full result register holds the sequencer.
module text_console_writer_core (
  input  logic       clk,
  input  logic       rst,
  tcw_req_if.sink    req,
  tcw_rsp_if.source  rsp,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic [7:0]             attr;
  tcw_pkg::cmd_t          cmd;
  tcw_pkg::result_t       res;
  logic                   res_valid;
  logic                   res_ready;
  tcw_pkg::ram_wr_t       ram_wr;
  logic [tcw_pkg::AW-1:0] ram_raddr;
  logic [15:0]            ram_rdata;
  logic                   out_valid;
  tcw_pkg::result_t       out_res;

  // text_attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= tcw_pkg::ATTR_RESET;
    end else if (cfg_we) begin
      attr <= cfg_wdata;
    end
  end

  assign cmd.opcode     = req.opcode;
  assign cmd.char_code  = req.char_code;
  assign cmd.cell_index = req.cell_index;

  tcw_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .attr      (attr),
    .cmd_valid (req.valid),
    .cmd_ready (req.ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_wr    (ram_wr),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  tcw_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result register: loads when empty or draining this cycle
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_data  = out_res.read_data;
  assign rsp.cursor_row = out_res.cursor_row;
  assign rsp.cursor_col = out_res.cursor_col;

`ifndef SYNTHESIS
  // the sequencer is busy in the cycle after every accepted request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken on two consecutive cycles");

  // cursor never leaves the screen (column may sit at COLS for a pending wrap)
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (32'(rsp.cursor_col) <= tcw_pkg::COLS &&
                   32'(rsp.cursor_row) < tcw_pkg::ROWS))
    else $error("cursor outside screen");

  // cell writes stay inside the store
  a_write_range: assert property (@(posedge clk) disable iff (rst)
    ram_wr.we |-> 32'(ram_wr.addr) < tcw_pkg::CELLS)
    else $error("cell write beyond store");

  // a finished result never overwrites one still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready && res_valid) |=> res_valid)
    else $error("sequencer dropped a result");
`endif

endmodule
